// File: hdl/prrs_pkg.sv
// Shared types and constants for the priority round-robin scheduler.
// Used by the channel interfaces, the controller, the datapath and the checker.
`default_nettype none

package prrs_pkg;

  localparam int unsigned MAX_TASKS_DEF = 16;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 4;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned Q_W    = 8;

  localparam logic [ID_W-1:0] LAST_ID_RST = 16'd1;
  localparam logic [Q_W-1:0]  QUANTUM_RST = 8'd10;

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_priority;
    logic [Q_W-1:0]    slice_run;
    logic [TIME_W-1:0] remaining_after;
    logic              finished;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch the input beat
    logic decode;     // handle add / empty step, or start the scan
    logic scan_rd;    // read the next entry for the priority scan
    logic shift_set;  // point past the chosen entry
    logic shift_rd;   // read the next entry to move down by one
    logic run;        // run the slice, requeue or drop the task
    logic out_load;   // move the result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_step;
    logic empty;
    logic scan_last;
    logic shift_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: hdl/prrs_if.sv
// Valid/ready channel interfaces for the scheduler's request and result beats.
// Depends on prrs_pkg for field widths.
`default_nettype none

interface prrs_in_if
  import prrs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [PRIO_W-1:0] priority_req;
  logic [TIME_W-1:0] burst;

  modport source (output valid, output action, output priority_req, output burst,
                  input ready);
  modport sink   (input valid, input action, input priority_req, input burst,
                  output ready);
endinterface

interface prrs_out_if
  import prrs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] task_priority;
  logic [Q_W-1:0]    slice_run;
  logic [TIME_W-1:0] remaining_after;
  logic              finished;

  modport source (output valid, output status, output task_id, output task_priority,
                  output slice_run, output remaining_after, output finished,
                  input ready);
  modport sink   (input valid, input status, input task_id, input task_priority,
                  input slice_run, input remaining_after, input finished,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/prrs_ctrl.sv
// Sequencing state machine of the scheduler: add, scan, compact, run, output.
// Depends on prrs_pkg for the command and status structs.
`default_nettype none

module prrs_ctrl
  import prrs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DEC       = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_SCAN_END  = 3'd3;
  localparam logic [2:0] S_SHIFT_SET = 3'd4;
  localparam logic [2:0] S_SHIFT     = 3'd5;
  localparam logic [2:0] S_RUN       = 3'd6;
  localparam logic [2:0] S_OUT       = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.decode = 1'b1;
        state_d      = (sts_i.is_step && !sts_i.empty) ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = S_SCAN_END;
      end
      // last compare lands here
      S_SCAN_END: state_d = S_SHIFT_SET;
      S_SHIFT_SET: begin
        cmd_o.shift_set = 1'b1;
        state_d         = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = S_RUN;
        end else begin
          cmd_o.shift_rd = 1'b1;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/prrs_dp.sv
// Scheduler datapath: task queue memory, count, id and quantum registers,
// priority scan, compaction, slice arithmetic and the output register.
// Depends on prrs_pkg; driven by prrs_ctrl through ctrl_cmd_t / ctrl_sts_t.
`default_nettype none

module prrs_dp
  import prrs_pkg::*;
#(
  parameter int unsigned MaxTasks = MAX_TASKS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [Q_W-1:0]    cfg_wdata_i,
  input  wire logic              action_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  input  wire logic [TIME_W-1:0] burst_i,
  input  wire ctrl_cmd_t         cmd_i,
  output ctrl_sts_t              sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output res_t                   out_o
);

  localparam int unsigned CW = $clog2(MaxTasks + 1);
  localparam int unsigned AW = $clog2(MaxTasks);

  entry_t mem [MaxTasks];

  logic [CW-1:0]     count_q;
  logic [ID_W-1:0]   last_id_q;
  logic [Q_W-1:0]    quantum_q;
  logic [CW-1:0]     ptr_q;
  logic              cmp_pend_q, sh_pend_q;
  logic              out_vld_q;
  entry_t            rd_q;
  logic [AW-1:0]     rd_idx_q;
  entry_t            best_q;
  logic [AW-1:0]     best_idx_q;
  logic              act_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TIME_W-1:0] burst_q;
  res_t              res_q, res_d;
  res_t              out_q;

  logic [CW-1:0]     cnt_m1;
  logic              full;
  logic [ID_W-1:0]   next_id;
  logic [Q_W-1:0]    q_eff;
  logic [Q_W-1:0]    slice;
  logic [TIME_W-1:0] new_rem;
  logic              add_ok;
  logic              requeue;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;

  assign cnt_m1  = count_q - CW'(1);
  assign full    = (count_q == CW'(MaxTasks));
  assign next_id = last_id_q + ID_W'(1);
  assign q_eff   = (quantum_q == '0) ? Q_W'(1) : quantum_q;
  assign slice   = (best_q.rem < TIME_W'(q_eff)) ? best_q.rem[Q_W-1:0] : q_eff;
  assign new_rem = best_q.rem - TIME_W'(slice);
  assign add_ok  = cmd_i.decode && (act_q == ACT_ADD) && !full;
  assign requeue = cmd_i.run && (new_rem != '0);

  assign sts_o.is_step    = (act_q == ACT_STEP);
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.scan_last  = (ptr_q == cnt_m1);
  assign sts_o.shift_done = (ptr_q == count_q);
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // single write port: compaction, append on add, requeue after a slice
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_q - AW'(1);
    wdata = rd_q;
    if (sh_pend_q) begin
      we = 1'b1;
    end else if (add_ok) begin
      we    = 1'b1;
      waddr = count_q[AW-1:0];
      wdata = '{id: next_id, prio: prio_q, rem: burst_q};
    end else if (requeue) begin
      we    = 1'b1;
      waddr = cnt_m1[AW-1:0];
      wdata = '{id: best_q.id, prio: best_q.prio, rem: new_rem};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q     <= mem[ptr_q[AW-1:0]];
    rd_idx_q <= ptr_q[AW-1:0];
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.decode) begin
      res_d = '0;
      if (act_q == ACT_ADD) begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.status  = ST_ADDED;
          res_d.task_id = next_id;
        end
      end else begin
        res_d.status = ST_EMPTY;
      end
    end else if (cmd_i.run) begin
      res_d.status          = ST_RUN;
      res_d.task_id         = best_q.id;
      res_d.task_priority   = best_q.prio;
      res_d.slice_run       = slice;
      res_d.remaining_after = new_rem;
      res_d.finished        = (new_rem == '0);
    end
  end

  // payload, result, best-entry and pointer registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q   <= action_i;
      prio_q  <= priority_req_i;
      burst_q <= burst_i;
    end
    res_q <= res_d;
    if (cmd_i.out_load) out_q <= res_q;
    // the first entry seeds the scan; later ones win only on strictly higher priority
    if (cmp_pend_q && ((rd_idx_q == '0) || (rd_q.prio > best_q.prio))) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.decode) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_rd || cmd_i.shift_rd) begin
      ptr_q <= ptr_q + CW'(1);
    end else if (cmd_i.shift_set) begin
      ptr_q <= CW'(best_idx_q) + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      last_id_q  <= LAST_ID_RST;
      quantum_q  <= QUANTUM_RST;
      cmp_pend_q <= 1'b0;
      sh_pend_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) quantum_q <= cfg_wdata_i;
      cmp_pend_q <= cmd_i.scan_rd;
      sh_pend_q  <= cmd_i.shift_rd;
      if (add_ok) begin
        count_q   <= count_q + CW'(1);
        last_id_q <= next_id;
      end else if (cmd_i.run && !requeue) begin
        count_q <= cnt_m1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/priority_round_robin_scheduler_top.sv
// Priority round-robin scheduler, one request beat at a time. An add beat passes
// through the accept, decode and output states before the next beat is taken. A
// step beat on a non-empty queue goes on from decode through the scan, scan-end,
// shift-set, shift and run states; an empty-queue step goes straight to output.
// The queue memory has a single read port, which first scans every entry for the
// highest priority and then moves each entry behind the chosen one down by one
// place. The result sits in an output register, so the next request is taken
// while it waits to be read; a result still unread when the next one is done
// holds the block in its output state. The user must write the quantum register
// with cfg_we_i only while the block is idle; the block itself does not enforce it.
`default_nettype none

module priority_round_robin_scheduler_top
  import prrs_pkg::*;
#(
  parameter int unsigned MaxTasks = MAX_TASKS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [Q_W-1:0] cfg_wdata_i,
  prrs_in_if.sink             in_ch,
  prrs_out_if.source          out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  res_t      res;
  logic      in_ready;
  logic      out_valid;

  prrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prrs_dp #(
    .MaxTasks (MaxTasks)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .action_i       (in_ch.action),
    .priority_req_i (in_ch.priority_req),
    .burst_i        (in_ch.burst),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_valid),
    .out_o          (res)
  );

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.status          = res.status;
  assign out_ch.task_id         = res.task_id;
  assign out_ch.task_priority   = res.task_priority;
  assign out_ch.slice_run       = res.slice_run;
  assign out_ch.remaining_after = res.remaining_after;
  assign out_ch.finished        = res.finished;

endmodule

`default_nettype wire

// File: hdl/prrs_chk.sv
// Port-level checker for the scheduler, attached to the top level by bind.
// Depends on prrs_pkg for the status codes.
`default_nettype none

module prrs_chk
  import prrs_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [1:0]        status_i,
  input wire logic [ID_W-1:0]   task_id_i,
  input wire logic [Q_W-1:0]    slice_run_i,
  input wire logic [TIME_W-1:0] remaining_after_i,
  input wire logic              finished_i
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(task_id_i))
    else $error("result beat changed while stalled");

  // one request in flight: no second beat right after acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in flight");

  a_finish_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_RUN) |-> (finished_i == (remaining_after_i == '0)))
    else $error("finished flag disagrees with remaining time");

  a_no_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_RUN) |->
      (slice_run_i == '0) && (remaining_after_i == '0) && !finished_i)
    else $error("slice fields set on a non-run result");

endmodule

bind priority_round_robin_scheduler_top prrs_chk u_prrs_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_ch.valid),
  .in_ready_i        (in_ch.ready),
  .out_valid_i       (out_ch.valid),
  .out_ready_i       (out_ch.ready),
  .status_i          (out_ch.status),
  .task_id_i         (out_ch.task_id),
  .slice_run_i       (out_ch.slice_run),
  .remaining_after_i (out_ch.remaining_after),
  .finished_i        (out_ch.finished)
);

`default_nettype wire
